/* hw/rtl/tcl_pkg.sv */
// ----------------------------------------------------------------------------
// tcl_pkg
// Shared widths, codes and controller/datapath interface types for the tone
// curve table engine.
// ----------------------------------------------------------------------------
package tcl_pkg;

  localparam int CNT_W = 11;
  localparam int IDX_W = 10;
  localparam int SMP_W = 16;
  localparam int OP_W  = 2;

  localparam logic [SMP_W-1:0] FULL_SCALE = 16'hFFFF;

  localparam logic [OP_W-1:0] OP_LOAD = 2'd0;
  localparam logic [OP_W-1:0] OP_FWD  = 2'd1;
  localparam logic [OP_W-1:0] OP_INV  = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_FMUL,
    S_FSPLIT,
    S_FRDLO,
    S_FRDHI,
    S_FYHI,
    S_FM1,
    S_FM2,
    S_FSUM,
    S_FRES,
    S_ISCAN,
    S_IDRAIN,
    S_IDIV,
    S_IWAIT,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    MUL_SCALE,
    MUL_LO,
    MUL_HI
  } mul_sel_t;

  typedef enum logic [1:0] {
    RD_SCAN,
    RD_LO,
    RD_HI
  } rd_sel_t;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD
  } acc_op_t;

  typedef enum logic [2:0] {
    RES_ZERO,
    RES_SAMPLE,
    RES_GAMMA,
    RES_FWD,
    RES_INV
  } res_sel_t;

  typedef struct packed {
    logic     capture;
    logic     ram_we;
    mul_sel_t mul_sel;
    logic     prod_en;
    logic     split_en;
    rd_sel_t  rd_sel;
    logic     ylo_en;
    logic     yhi_en;
    acc_op_t  acc_op;
    logic     scan_clr;
    logic     scan_step;
    logic     div_start;
    logic     res_load;
    res_sel_t res_sel;
    logic     out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            n_zero;
    logic            n_one;
    logic            scan_last;
    logic            div_done;
    logic            out_free;
  } ctrl_sts_t;

endpackage

/* hw/rtl/tone_curve_lut_forward_inverse.sv */
// Load and degenerate cases go from decode straight to done; forward steps through
// scale, split, two table reads, two products, sum and result; inverse scans the
// n entries in use, then divides. Throughput: one transaction at a time; the next
// is taken in the cycle after the result moves to the output register.
// Inverse time is set by the one-entry-per-cycle table scan plus the bit-serial divider.
// Reset (synchronous, active high) clears the entry count and control; table words stay.
// ----------------------------------------------------------------------------
// tone_curve_lut_forward_inverse
// Tone curve table engine: loads curve words and maps samples through the
// curve by linear interpolation or by nearest-entry inverse lookup.
// ----------------------------------------------------------------------------
module tone_curve_lut_forward_inverse #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [tcl_pkg::CNT_W-1:0] cfg_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [tcl_pkg::OP_W-1:0]  op,
  input  logic [tcl_pkg::IDX_W-1:0] entry_index,
  input  logic [tcl_pkg::SMP_W-1:0] sample,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [tcl_pkg::SMP_W-1:0] result_value,
  output logic                      status
);

  tcl_pkg::ctrl_cmd_t cmd;
  tcl_pkg::ctrl_sts_t sts;

  tcl_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .sts     (sts),
    .cmd     (cmd)
  );

  tcl_datapath #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data),
    .op          (op),
    .entry_index (entry_index),
    .sample      (sample),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .result_value(result_value),
    .status      (status),
    .cmd         (cmd),
    .sts         (sts)
  );

endmodule

/* hw/rtl/tcl_ram.sv */
// ----------------------------------------------------------------------------
// tcl_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module tcl_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/tcl_div.sv */
// ----------------------------------------------------------------------------
// tcl_div
// Restoring divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tcl_div #(
  parameter int NUM_W = 27,
  parameter int DEN_W = 11
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] numer,
  input  logic [DEN_W-1:0] denom,
  output logic [NUM_W-1:0] quot,
  output logic             done
);

  localparam int CB = $clog2(NUM_W);

  logic [DEN_W-1:0] rem;
  logic [NUM_W-1:0] quo;
  logic [DEN_W-1:0] den;
  logic [CB-1:0]    cnt;
  logic             busy;
  logic [DEN_W:0]   trial;
  logic             ge;

  assign trial = {rem, quo[NUM_W-1]};
  assign ge    = trial >= {1'b0, den};
  assign quot  = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == CB'(NUM_W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= numer;
      den <= denom;
      cnt <= '0;
    end else if (busy) begin
      rem <= ge ? DEN_W'(trial - {1'b0, den}) : trial[DEN_W-1:0];
      quo <= {quo[NUM_W-2:0], ge};
      cnt <= cnt + CB'(1);
    end
  end

endmodule

/* hw/rtl/tcl_datapath.sv */
// ----------------------------------------------------------------------------
// tcl_datapath
// Curve table, shared multiplier, nearest-entry scan, divider and the
// result and output registers of the tone curve table engine.
// ----------------------------------------------------------------------------
module tcl_datapath #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [tcl_pkg::CNT_W-1:0] cfg_data,
  input  logic [tcl_pkg::OP_W-1:0]  op,
  input  logic [tcl_pkg::IDX_W-1:0] entry_index,
  input  logic [tcl_pkg::SMP_W-1:0] sample,
  input  logic                      out_ready,
  output logic                      out_valid,
  output logic [tcl_pkg::SMP_W-1:0] result_value,
  output logic                      status,
  input  tcl_pkg::ctrl_cmd_t        cmd,
  output tcl_pkg::ctrl_sts_t        sts
);

  localparam int ADDR_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W  = tcl_pkg::CNT_W;
  localparam int SMP_W  = tcl_pkg::SMP_W;
  localparam int NUM_W  = CNT_W + SMP_W;

  // Splits x into quotient and remainder by 65535, valid while the
  // remainder estimate stays below twice the full scale.
  function automatic logic [2*SMP_W-1:0] div_fs(input logic [2*SMP_W-1:0] x);
    logic [SMP_W-1:0] q0;
    logic [SMP_W:0]   r;
    q0 = x[2*SMP_W-1:SMP_W];
    r  = {1'b0, x[SMP_W-1:0]} + {1'b0, q0};
    if (r >= {1'b0, tcl_pkg::FULL_SCALE}) begin
      div_fs = {q0 + SMP_W'(1), SMP_W'(r - {1'b0, tcl_pkg::FULL_SCALE})};
    end else begin
      div_fs = {q0, r[SMP_W-1:0]};
    end
  endfunction

  logic [CNT_W-1:0]        count_n;
  logic [CNT_W-1:0]        n_m1;
  logic [tcl_pkg::OP_W-1:0]  op_q;
  logic [tcl_pkg::IDX_W-1:0] idx_q;
  logic [SMP_W-1:0]        smp_q;

  logic [SMP_W-1:0]        mul_a;
  logic [SMP_W-1:0]        mul_b;
  logic [2*SMP_W-1:0]      prod;
  logic [2*SMP_W-1:0]      acc;
  logic [2*SMP_W-1:0]      split;
  logic [2*SMP_W-1:0]      fwd_qr;
  logic [CNT_W-1:0]        lo;
  logic [SMP_W-1:0]        frac;
  logic [SMP_W-1:0]        y_lo;
  logic [SMP_W-1:0]        y_hi;

  logic [ADDR_W-1:0]       raddr;
  logic [SMP_W-1:0]        rdata;
  logic                    wr_ok;

  logic [CNT_W-1:0]        scan_idx;
  logic [CNT_W-1:0]        pend_idx;
  logic                    pend;
  logic [SMP_W-1:0]        diff;
  logic [SMP_W:0]          best_diff;
  logic [CNT_W-1:0]        best_idx;

  logic [NUM_W-1:0]        div_num;
  logic [NUM_W-1:0]        div_quot;
  logic                    div_done;

  logic [SMP_W-1:0]        res_val;
  logic                    res_st;

  assign n_m1 = count_n - CNT_W'(1);

  // Entry count, saturated to the table depth when written.
  always_ff @(posedge clk) begin
    if (rst) begin
      count_n <= '0;
    end else if (cfg_we) begin
      if (32'(cfg_data) > TABLE_DEPTH) begin
        count_n <= CNT_W'(TABLE_DEPTH);
      end else begin
        count_n <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q  <= op;
      idx_q <= entry_index;
      smp_q <= sample;
    end
  end

  // Table memory.
  assign wr_ok = cmd.ram_we && (32'(idx_q) < TABLE_DEPTH);

  always_comb begin
    case (cmd.rd_sel)
      tcl_pkg::RD_LO: raddr = ADDR_W'(lo);
      tcl_pkg::RD_HI: raddr = ADDR_W'(lo + CNT_W'(1));
      default:        raddr = ADDR_W'(scan_idx);
    endcase
  end

  tcl_ram #(
    .WIDTH(SMP_W),
    .DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk  (clk),
    .we   (wr_ok),
    .waddr(ADDR_W'(idx_q)),
    .wdata(smp_q),
    .raddr(raddr),
    .rdata(rdata)
  );

  // Shared multiplier; 65535 - frac is the bitwise complement of frac.
  always_comb begin
    case (cmd.mul_sel)
      tcl_pkg::MUL_LO: begin
        mul_a = y_lo;
        mul_b = ~frac;
      end
      tcl_pkg::MUL_HI: begin
        mul_a = y_hi;
        mul_b = frac;
      end
      default: begin
        mul_a = SMP_W'(n_m1);
        mul_b = smp_q;
      end
    endcase
  end

  assign split  = div_fs(prod);
  assign fwd_qr = div_fs(acc);

  always_ff @(posedge clk) begin
    if (cmd.prod_en) begin
      prod <= mul_a * mul_b;
    end
    if (cmd.split_en) begin
      lo   <= CNT_W'(split[2*SMP_W-1:SMP_W]);
      frac <= split[SMP_W-1:0];
    end
    if (cmd.ylo_en) begin
      y_lo <= rdata;
    end
    if (cmd.yhi_en) begin
      y_hi <= rdata;
    end
    case (cmd.acc_op)
      tcl_pkg::ACC_LOAD: acc <= prod;
      tcl_pkg::ACC_ADD:  acc <= acc + prod;
      default:           acc <= acc;
    endcase
  end

  // Nearest-entry scan; a later entry wins a tie.
  assign diff = (rdata >= smp_q) ? (rdata - smp_q) : (smp_q - rdata);

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else begin
      pend <= cmd.scan_step;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_clr) begin
      scan_idx  <= '0;
      best_diff <= '1;
      best_idx  <= '0;
    end else begin
      if (cmd.scan_step) begin
        scan_idx <= scan_idx + CNT_W'(1);
        pend_idx <= scan_idx;
      end
      if (pend && ({1'b0, diff} <= best_diff)) begin
        best_diff <= {1'b0, diff};
        best_idx  <= pend_idx;
      end
    end
  end

  // best_idx * 65535 as a shift and a subtract.
  assign div_num = {best_idx, SMP_W'(0)} - NUM_W'(best_idx);

  tcl_div #(
    .NUM_W(NUM_W),
    .DEN_W(CNT_W)
  ) u_div (
    .clk  (clk),
    .rst  (rst),
    .start(cmd.div_start),
    .numer(div_num),
    .denom(n_m1),
    .quot (div_quot),
    .done (div_done)
  );

  // Result register, then the output register toward the consumer.
  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      res_st <= 1'b0;
      case (cmd.res_sel)
        tcl_pkg::RES_SAMPLE: res_val <= smp_q;
        tcl_pkg::RES_GAMMA: begin
          res_val <= '0;
          res_st  <= 1'b1;
        end
        tcl_pkg::RES_FWD: begin
          res_val <= (frac == '0) ? y_lo : fwd_qr[2*SMP_W-1:SMP_W];
        end
        tcl_pkg::RES_INV: res_val <= div_quot[SMP_W-1:0];
        default:          res_val <= '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      result_value <= res_val;
      status       <= res_st;
    end
  end

  always_comb begin
    sts.op        = op_q;
    sts.n_zero    = (count_n == '0);
    sts.n_one     = (count_n == CNT_W'(1));
    sts.scan_last = (scan_idx == n_m1);
    sts.div_done  = div_done;
    sts.out_free  = !out_valid || out_ready;
  end

endmodule

/* hw/rtl/tcl_ctrl.sv */
// ----------------------------------------------------------------------------
// tcl_ctrl
// Sequencer for the tone curve table engine: decodes each transaction and
// steps the datapath through load, forward or inverse evaluation.
// ----------------------------------------------------------------------------
module tcl_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  tcl_pkg::ctrl_sts_t sts,
  output tcl_pkg::ctrl_cmd_t cmd
);

  tcl_pkg::state_t state;
  tcl_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tcl_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      tcl_pkg::S_IDLE: begin
        if (in_valid) begin
          state_next = tcl_pkg::S_DECODE;
        end
      end
      tcl_pkg::S_DECODE: begin
        case (sts.op)
          tcl_pkg::OP_FWD, tcl_pkg::OP_INV: begin
            if (sts.n_zero || sts.n_one) begin
              state_next = tcl_pkg::S_DONE;
            end else if (sts.op == tcl_pkg::OP_FWD) begin
              state_next = tcl_pkg::S_FMUL;
            end else begin
              state_next = tcl_pkg::S_ISCAN;
            end
          end
          default: state_next = tcl_pkg::S_DONE;
        endcase
      end
      tcl_pkg::S_FMUL:   state_next = tcl_pkg::S_FSPLIT;
      tcl_pkg::S_FSPLIT: state_next = tcl_pkg::S_FRDLO;
      tcl_pkg::S_FRDLO:  state_next = tcl_pkg::S_FRDHI;
      tcl_pkg::S_FRDHI:  state_next = tcl_pkg::S_FYHI;
      tcl_pkg::S_FYHI:   state_next = tcl_pkg::S_FM1;
      tcl_pkg::S_FM1:    state_next = tcl_pkg::S_FM2;
      tcl_pkg::S_FM2:    state_next = tcl_pkg::S_FSUM;
      tcl_pkg::S_FSUM:   state_next = tcl_pkg::S_FRES;
      tcl_pkg::S_FRES:   state_next = tcl_pkg::S_DONE;
      tcl_pkg::S_ISCAN: begin
        if (sts.scan_last) begin
          state_next = tcl_pkg::S_IDRAIN;
        end
      end
      tcl_pkg::S_IDRAIN: state_next = tcl_pkg::S_IDIV;
      tcl_pkg::S_IDIV:   state_next = tcl_pkg::S_IWAIT;
      tcl_pkg::S_IWAIT: begin
        if (sts.div_done) begin
          state_next = tcl_pkg::S_DONE;
        end
      end
      tcl_pkg::S_DONE: begin
        if (sts.out_free) begin
          state_next = tcl_pkg::S_IDLE;
        end
      end
      default: state_next = tcl_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = 1'b0;
    cmd.capture   = 1'b0;
    cmd.ram_we    = 1'b0;
    cmd.mul_sel   = tcl_pkg::MUL_SCALE;
    cmd.prod_en   = 1'b0;
    cmd.split_en  = 1'b0;
    cmd.rd_sel    = tcl_pkg::RD_SCAN;
    cmd.ylo_en    = 1'b0;
    cmd.yhi_en    = 1'b0;
    cmd.acc_op    = tcl_pkg::ACC_HOLD;
    cmd.scan_clr  = 1'b0;
    cmd.scan_step = 1'b0;
    cmd.div_start = 1'b0;
    cmd.res_load  = 1'b0;
    cmd.res_sel   = tcl_pkg::RES_ZERO;
    cmd.out_load  = 1'b0;
    case (state)
      tcl_pkg::S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      tcl_pkg::S_DECODE: begin
        case (sts.op)
          tcl_pkg::OP_LOAD: begin
            cmd.ram_we   = 1'b1;
            cmd.res_load = 1'b1;
            cmd.res_sel  = tcl_pkg::RES_ZERO;
          end
          tcl_pkg::OP_FWD, tcl_pkg::OP_INV: begin
            if (sts.n_zero) begin
              cmd.res_load = 1'b1;
              cmd.res_sel  = tcl_pkg::RES_SAMPLE;
            end else if (sts.n_one) begin
              cmd.res_load = 1'b1;
              cmd.res_sel  = tcl_pkg::RES_GAMMA;
            end else if (sts.op == tcl_pkg::OP_INV) begin
              cmd.scan_clr = 1'b1;
            end
          end
          default: begin
            cmd.res_load = 1'b1;
            cmd.res_sel  = tcl_pkg::RES_ZERO;
          end
        endcase
      end
      tcl_pkg::S_FMUL: begin
        cmd.mul_sel = tcl_pkg::MUL_SCALE;
        cmd.prod_en = 1'b1;
      end
      tcl_pkg::S_FSPLIT: cmd.split_en = 1'b1;
      tcl_pkg::S_FRDLO:  cmd.rd_sel = tcl_pkg::RD_LO;
      tcl_pkg::S_FRDHI: begin
        cmd.rd_sel = tcl_pkg::RD_HI;
        cmd.ylo_en = 1'b1;
      end
      tcl_pkg::S_FYHI: cmd.yhi_en = 1'b1;
      tcl_pkg::S_FM1: begin
        cmd.mul_sel = tcl_pkg::MUL_LO;
        cmd.prod_en = 1'b1;
      end
      tcl_pkg::S_FM2: begin
        cmd.mul_sel = tcl_pkg::MUL_HI;
        cmd.prod_en = 1'b1;
        cmd.acc_op  = tcl_pkg::ACC_LOAD;
      end
      tcl_pkg::S_FSUM: cmd.acc_op = tcl_pkg::ACC_ADD;
      tcl_pkg::S_FRES: begin
        cmd.res_load = 1'b1;
        cmd.res_sel  = tcl_pkg::RES_FWD;
      end
      tcl_pkg::S_ISCAN: begin
        cmd.rd_sel    = tcl_pkg::RD_SCAN;
        cmd.scan_step = 1'b1;
      end
      tcl_pkg::S_IDIV: cmd.div_start = 1'b1;
      tcl_pkg::S_IWAIT: begin
        if (sts.div_done) begin
          cmd.res_load = 1'b1;
          cmd.res_sel  = tcl_pkg::RES_INV;
        end
      end
      tcl_pkg::S_DONE: cmd.out_load = sts.out_free;
      default: begin
      end
    endcase
  end

  // An accepted transaction is always decoded in the following cycle.
  a_accept_decode: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == tcl_pkg::S_DECODE))
    else $error("accepted transaction not decoded");

  a_out_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> sts.out_free)
    else $error("output register overwritten while occupied");

  a_ram_we_load: assert property (@(posedge clk) disable iff (rst)
    cmd.ram_we |-> (state == tcl_pkg::S_DECODE && sts.op == tcl_pkg::OP_LOAD))
    else $error("table written outside a load transaction");

  a_div_finish: assert property (@(posedge clk) disable iff (rst)
    (state == tcl_pkg::S_IWAIT && sts.div_done) |=> (state == tcl_pkg::S_DONE))
    else $error("inverse result not taken from divider");

endmodule

/* tb/sv/tone_curve_lut_forward_inverse_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tone_curve_lut_forward_inverse_test
// Loads curve tables of many shapes and sizes and pushes forward and inverse
// samples through the engine. Both handshakes stall at random. A scoreboard
// class predicts each mapped sample and compares the results in order.
// ----------------------------------------------------------------------------
module tone_curve_lut_forward_inverse_test;

  localparam int     CNT_W          = tcl_pkg::CNT_W;
  localparam int     IDX_W          = tcl_pkg::IDX_W;
  localparam int     SMP_W          = tcl_pkg::SMP_W;
  localparam int     OP_W           = tcl_pkg::OP_W;

  localparam int     DEPTH          = 1024;
  localparam int     WATCHDOG_LIMIT = 8000;
  localparam int     SETTLE_CYCLES  = 64;
  localparam int     RANDOM_ITEMS   = 520;
  localparam longint UNITY          = 65535;

  localparam logic [OP_W-1:0] OP_LOAD   = tcl_pkg::OP_LOAD;
  localparam logic [OP_W-1:0] OP_FWD    = tcl_pkg::OP_FWD;
  localparam logic [OP_W-1:0] OP_INV    = tcl_pkg::OP_INV;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam logic            ST_OK     = 1'b0;
  localparam logic            ST_GAMMA  = 1'b1;

  typedef struct packed {
    logic [SMP_W-1:0] value;
    logic             status;
  } mapped_t;

  typedef enum {CURVE_RISING, CURVE_FALLING, CURVE_NOISE, CURVE_STEPS} curve_shape_t;

  class tone_map_scoreboard;
    logic [SMP_W-1:0] curve [0:DEPTH-1];
    bit               loaded [0:DEPTH-1];
    logic [CNT_W-1:0] entry_count = '0;
    mapped_t          pending_maps [$];
    int               mismatches;
    int               loads;
    int               forwards;
    int               inverses;
    int               unused_ops;

    function int unsigned entries_used();
      return (entry_count > DEPTH) ? DEPTH : entry_count;
    endfunction

    function logic [SMP_W-1:0] interp_forward(logic [SMP_W-1:0] smp, int unsigned n);
      longint unsigned num;
      int unsigned     lo;
      int unsigned     frac;
      longint          y_lo;
      longint          y_hi;
      longint          acc;
      num  = longint'(n - 1) * smp;
      lo   = num / UNITY;
      frac = num % UNITY;
      y_lo = curve[lo];
      if (frac == 0) return y_lo[SMP_W-1:0];
      y_hi = curve[lo + 1];
      acc  = y_lo * UNITY + (y_hi - y_lo) * longint'(frac);
      if (acc < 0) acc = 0;
      return SMP_W'(acc / UNITY);
    endfunction

    // Ties go to the later entry, so a flat run maps to its last index.
    function logic [SMP_W-1:0] nearest_inverse(logic [SMP_W-1:0] smp, int unsigned n);
      int unsigned best_idx;
      longint      best_diff;
      longint      d;
      best_idx  = 0;
      best_diff = 64'h7FFF_FFFF_FFFF_FFFF;
      for (int unsigned i = 0; i < n; i++) begin
        d = longint'(curve[i]) - longint'(smp);
        if (d < 0) d = -d;
        if (d <= best_diff) begin
          best_diff = d;
          best_idx  = i;
        end
      end
      return SMP_W'((longint'(best_idx) * UNITY) / longint'(n - 1));
    endfunction

    function void note_sample_in(logic [OP_W-1:0] code, logic [IDX_W-1:0] idx,
                                 logic [SMP_W-1:0] smp);
      mapped_t     want;
      int unsigned n;
      n           = entries_used();
      want.value  = '0;
      want.status = ST_OK;
      case (code)
        OP_LOAD: begin
          curve[idx]  = smp;
          loaded[idx] = 1'b1;
          loads++;
        end
        OP_FWD, OP_INV: begin
          if (code == OP_FWD) forwards++;
          else inverses++;
          if (n == 0) want.value = smp;
          else if (n == 1) want.status = ST_GAMMA;
          else if (code == OP_FWD) want.value = interp_forward(smp, n);
          else want.value = nearest_inverse(smp, n);
        end
        default: unused_ops++;
      endcase
      pending_maps.push_back(want);
    endfunction

    function void check_mapped_out(logic [SMP_W-1:0] value, logic st);
      mapped_t want;
      if (pending_maps.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual value %h status %b",
                 $time, value, st);
        mismatches++;
        return;
      end
      want = pending_maps.pop_front();
      if (value !== want.value) begin
        $display("%0t: result_value expected %h actual %h", $time, want.value, value);
        mismatches++;
      end
      if (st !== want.status) begin
        $display("%0t: status expected %b actual %b", $time, want.status, st);
        mismatches++;
      end
    endfunction
  endclass

  logic             clk         = 1'b0;
  logic             rst         = 1'b1;
  logic             cfg_we      = 1'b0;
  logic [CNT_W-1:0] cfg_data    = '0;
  logic             in_valid    = 1'b0;
  logic             in_ready;
  logic [OP_W-1:0]  op          = OP_LOAD;
  logic [IDX_W-1:0] entry_index = '0;
  logic [SMP_W-1:0] sample      = '0;
  logic             out_valid;
  logic             out_ready   = 1'b0;
  logic [SMP_W-1:0] result_value;
  logic             status;

  tone_map_scoreboard maps = new();

  bit          no_idle;
  int          idle_cycles;
  int          sent_items;
  int          count_writes;
  int unsigned largest_count;

  tone_curve_lut_forward_inverse #(.TABLE_DEPTH(DEPTH)) DUT (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .op           (op),
    .entry_index  (entry_index),
    .sample       (sample),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .result_value (result_value),
    .status       (status)
  );

  always #2 clk = ~clk;

  function automatic int draw_gap();
    return no_idle ? 0 : $urandom_range(0, 16);
  endfunction

  // Called at a rising edge; returns at the edge where the transaction is taken.
  task automatic send_item(input logic [OP_W-1:0] code, input logic [IDX_W-1:0] idx,
                           input logic [SMP_W-1:0] smp);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    op          <= code;
    entry_index <= idx;
    sample      <= smp;
    do @(posedge clk); while (!in_ready);
    maps.note_sample_in(code, idx, smp);
    sent_items++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (maps.pending_maps.size() != 0);
  endtask

  task automatic set_entry_count(input logic [CNT_W-1:0] value);
    wait_idle();
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    maps.entry_count = value;
    count_writes++;
    if (maps.entries_used() > largest_count) largest_count = maps.entries_used();
    @(posedge clk);
  endtask

  task automatic load_curve(input int unsigned n, input curve_shape_t shape);
    int level;
    int step;
    step  = 2 * 65535 / (n + 1) + 1;
    level = $urandom_range(0, 4095);
    if (shape == CURVE_FALLING) level = 65535 - level;
    for (int unsigned i = 0; i < n; i++) begin
      case (shape)
        CURVE_RISING:  level = (level + step > 65535) ? 65535 : level + $urandom_range(0, step);
        CURVE_FALLING: level = (level < step) ? 0 : level - $urandom_range(0, step);
        CURVE_NOISE:   level = $urandom_range(0, 65535);
        default:       if ($urandom_range(0, 2) == 0) level = $urandom_range(0, 65535);
      endcase
      send_item(OP_LOAD, IDX_W'(i), SMP_W'(level));
    end
  endtask

  // Extremes, exact table words (which hit inverse ties) and plain random values.
  function automatic logic [SMP_W-1:0] pick_sample(int unsigned n);
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3:    if (n > 0) return maps.curve[$urandom_range(0, n - 1)];
      default: ;
    endcase
    return SMP_W'($urandom_range(0, 65535));
  endfunction

  task automatic random_phase();
    int unsigned      n;
    int unsigned      pick;
    logic [CNT_W-1:0] count;
    bit               needs_load;
    logic [IDX_W-1:0] idx;
    pick = $urandom_range(0, 99);
    if (pick < 5) count = 0;
    else if (pick < 10) count = 1;
    else if (pick < 88) count = CNT_W'($urandom_range(2, 24));
    else count = CNT_W'($urandom_range(25, 300));
    set_entry_count(count);
    n          = maps.entries_used();
    no_idle    = ($urandom_range(0, 3) == 0);
    needs_load = $urandom_range(0, 1);
    for (int unsigned i = 0; i < n; i++)
      if (!maps.loaded[i]) needs_load = 1'b1;
    if (needs_load) load_curve(n, curve_shape_t'($urandom_range(0, 3)));
    repeat ($urandom_range(8, 30)) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) send_item(OP_FWD, IDX_W'($urandom), pick_sample(n));
      else if (pick < 80) send_item(OP_INV, IDX_W'($urandom), pick_sample(n));
      else if (pick < 95) begin
        // Rewrites inside the active range keep every entry in use written.
        idx = (n > 0 && $urandom_range(0, 1)) ? IDX_W'($urandom_range(0, n - 1))
                                              : IDX_W'($urandom_range(0, DEPTH - 1));
        send_item(OP_LOAD, idx, SMP_W'($urandom));
      end else send_item(OP_UNUSED, IDX_W'($urandom), SMP_W'($urandom));
    end
  endtask

  // At the full count these samples land only on the two lowest and the two
  // highest entries, so only those need to be written.
  task automatic full_table_checks();
    send_item(OP_FWD, '0, '0);
    send_item(OP_FWD, '1, '1);
    send_item(OP_FWD, '0, 16'hFFFE);
    repeat (2) send_item(OP_FWD, IDX_W'($urandom), SMP_W'($urandom_range(1, 64)));
  endtask

  // Results are taken with independent random stalls.
  initial begin
    int gap;
    while (rst) @(posedge clk);
    forever begin
      gap = draw_gap();
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      maps.check_mapped_out(result_value, status);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    int start_items;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Empty table passes samples through; the unused op returns zero.
    set_entry_count(0);
    send_item(OP_FWD, '0, '0);
    send_item(OP_FWD, '1, '1);
    send_item(OP_INV, '0, '0);
    send_item(OP_INV, '1, '1);
    send_item(OP_UNUSED, '1, '1);
    send_item(OP_LOAD, 10'd0, 16'h0000);
    send_item(OP_LOAD, 10'd1, 16'hFFFF);
    send_item(OP_LOAD, '1, 16'hA5A5);

    // A single entry would select the gamma mode, which is reported unsupported.
    set_entry_count(1);
    send_item(OP_FWD, '0, 16'h1234);
    send_item(OP_INV, '0, '1);

    set_entry_count(2);
    send_item(OP_FWD, '0, '0);
    send_item(OP_FWD, '0, '1);
    send_item(OP_FWD, '0, 16'h8000);
    send_item(OP_INV, '0, 16'h7FFF);
    send_item(OP_INV, '0, 16'h8000);
    send_item(OP_LOAD, 10'd0, 16'hFFFF);
    send_item(OP_LOAD, 10'd1, 16'h0000);
    send_item(OP_FWD, '0, 16'h5555);
    send_item(OP_LOAD, 10'd1, 16'hFFFF);
    send_item(OP_INV, '0, 16'h1234);

    start_items = sent_items;
    while (sent_items - start_items < RANDOM_ITEMS) random_phase();

    // Full count, then a count past the depth that must saturate.
    no_idle = 1'b0;
    send_item(OP_LOAD, 10'd0, SMP_W'($urandom));
    send_item(OP_LOAD, 10'd1, SMP_W'($urandom));
    send_item(OP_LOAD, IDX_W'(DEPTH - 2), SMP_W'($urandom));
    send_item(OP_LOAD, IDX_W'(DEPTH - 1), SMP_W'($urandom));
    set_entry_count(DEPTH);
    full_table_checks();
    set_entry_count('1);
    full_table_checks();

    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Covered %0d loads, %0d forward and %0d inverse maps, %0d unused-op transactions.",
             maps.loads, maps.forwards, maps.inverses, maps.unused_ops);
    $display("Table sizes up to %0d entries across %0d count settings, %0d mismatches.",
             largest_count, count_writes, maps.mismatches);
    if (maps.mismatches == 0 && maps.pending_maps.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/tcl_pkg.sv
hw/rtl/tcl_ram.sv
hw/rtl/tcl_div.sv
hw/rtl/tcl_datapath.sv
hw/rtl/tcl_ctrl.sv
hw/rtl/tone_curve_lut_forward_inverse.sv
tb/sv/tone_curve_lut_forward_inverse_test.sv
